>>> hdl/msw_pkg.sv
// package for the multi-sensor watch alarm
// types, codes and reset constants shared by every file of the block
`timescale 1ns / 1ps

package msw_pkg;

    // saturating persistence counter width, default
    localparam int unsigned COUNT_WIDTH_DEF = 4;

    // number of channels in channel_enable and fresh_mask
    localparam int unsigned NUM_CH  = 6;
    // channels with a persistence counter (all but pressure)
    localparam int unsigned NUM_CNT = 5;

    // channel bit positions
    localparam int unsigned CH_POS   = 0;
    localparam int unsigned CH_DEPTH = 1;
    localparam int unsigned CH_SOG   = 2;
    localparam int unsigned CH_WIND  = 3;
    localparam int unsigned CH_HEAD  = 4;
    localparam int unsigned CH_PRESS = 5;

    // consecutive ticks a channel must exceed, per counter
    localparam int unsigned QUAL_LIMIT [NUM_CNT] = '{9, 4, 4, 2, 4};

    // re-arm timing
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned REARM_GUARD_S = 5;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CHANNEL_ENABLE  = 3'd0,
        CFG_MIN_DEPTH_DM    = 3'd1,
        CFG_MAX_SOG_DKN     = 3'd2,
        CFG_MAX_WIND_KN     = 3'd3,
        CFG_MAX_HEADING_DEG = 3'd4,
        CFG_MAX_DISTANCE_M  = 3'd5,
        CFG_MAX_PRESSURE_MB = 3'd6,
        CFG_REARM_MINUTES   = 3'd7
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    // button codes
    typedef enum logic [1:0] {
        BTN_NONE   = 2'd0,
        BTN_TOP    = 2'd1,
        BTN_BOTTOM = 2'd2,
        BTN_LONG   = 2'd3
    } t_button;

    // alarm kinds
    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_NODATA = 3'd1,
        KIND_DEPTH  = 3'd2,
        KIND_SOG    = 3'd3,
        KIND_WIND   = 3'd4,
        KIND_DIST   = 3'd5,
        KIND_HEAD   = 3'd6,
        KIND_PRESS  = 3'd7
    } t_kind;

    // mode codes as reported in a result
    typedef enum logic [1:0] {
        MC_WAIT    = 2'd0,
        MC_STANDBY = 2'd1,
        MC_WATCH   = 2'd2,
        MC_ALARM   = 2'd3
    } t_mode_code;

    typedef struct packed {
        logic [5:0] channel_enable;
        logic [7:0] min_depth_dm;
        logic [5:0] max_sog_dkn;
        logic [5:0] max_wind_kn;
        logic [7:0] max_heading_deg;
        logic [6:0] max_distance_m;
        logic [4:0] max_pressure_mb;
        logic [7:0] rearm_minutes;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        channel_enable:  6'd0,
        min_depth_dm:    8'd20,
        max_sog_dkn:     6'd10,
        max_wind_kn:     6'd25,
        max_heading_deg: 8'd30,
        max_distance_m:  7'd30,
        max_pressure_mb: 5'd3,
        rearm_minutes:   8'd5
    };

    typedef struct packed {
        logic [31:0] time_s;
        logic [1:0]  button;
        logic [15:0] depth_cm;
        logic [15:0] sog_cknots;
        logic [7:0]  wind_knots;
        logic [8:0]  heading_now;
        logic [15:0] drift_dm;
        logic [14:0] pressure_dmb;
        logic [5:0]  fresh_mask;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         mode;
        logic [2:0]         alarm_kind;
        logic               buzzer_level;
        logic               backlight_flash;
        logic               setup_request;
        logic               rearming;
        logic [9:0]         heading_error;
        logic signed [15:0] pressure_delta_dmb;
    } t_out_item;

    // limit checks handed from the evaluator to the mode machine
    typedef struct packed {
        logic                all_ok;
        logic [NUM_CH-1:0]   over;
        logic [9:0]          heading_error;
        logic signed [15:0]  pressure_delta;
    } t_eval;

endpackage

>>> hdl/multi_sensor_watch_alarm_top.sv
// top level of the multi-sensor watch alarm: ports, config registers,
// input register and result register; depends on msw_pkg, msw_eval, msw_fsm
//
//  channel   | direction | signals                               | payload
//  ----------+-----------+---------------------------------------+-------------------
//  tick in   | in        | i_in_valid / o_in_ready / i_in_data   | msw_pkg::t_in_item
//  result    | out       | o_out_valid / i_out_ready / o_out_data| msw_pkg::t_out_item
//  config    | in        | i_cfg_we / i_cfg_index / i_cfg_data   | 8-bit register write
//
// one tick per clock sustained while the result side is ready; a tick is held in
// the input register, then passes through the mode logic into the result register
// the state registers update on the same edge that loads the result register,
// so the following tick sees the new mode at once
// synchronous active-low reset: modes, counters and config to their reset values
// a stalled result register holds the tick in the input register; o_in_ready
// is high while the input register is empty or empties on that edge
`timescale 1ns / 1ps

module multi_sensor_watch_alarm_top #(
    parameter int unsigned COUNT_WIDTH = msw_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // tick channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  msw_pkg::t_in_item                i_in_data,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output msw_pkg::t_out_item               o_out_data,
    // configuration writes
    input  logic                             i_cfg_we,
    input  logic [msw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [msw_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import msw_pkg::*;

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_item  r_in_data;
    logic      r_out_valid;
    t_out_item r_out_data;

    logic      w_fire;
    logic      w_in_take;
    t_eval     w_eval;
    t_out_item w_result;
    logic [8:0]  w_head_ref;
    logic [14:0] w_press_ref;

    // held tick moves into the result register when that register frees up
    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;
    assign w_in_take  = i_in_valid && o_in_ready;

    // configuration registers, fields masked to their widths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CHANNEL_ENABLE:  r_cfg.channel_enable  <= i_cfg_data[5:0];
                CFG_MIN_DEPTH_DM:    r_cfg.min_depth_dm    <= i_cfg_data;
                CFG_MAX_SOG_DKN:     r_cfg.max_sog_dkn     <= i_cfg_data[5:0];
                CFG_MAX_WIND_KN:     r_cfg.max_wind_kn     <= i_cfg_data[5:0];
                CFG_MAX_HEADING_DEG: r_cfg.max_heading_deg <= i_cfg_data;
                CFG_MAX_DISTANCE_M:  r_cfg.max_distance_m  <= i_cfg_data[6:0];
                CFG_MAX_PRESSURE_MB: r_cfg.max_pressure_mb <= i_cfg_data[4:0];
                CFG_REARM_MINUTES:   r_cfg.rearm_minutes   <= i_cfg_data;
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_data <= i_in_data;
        end
    end

    // limit checks on the held tick against current references
    msw_eval u_eval (
        .i_item      (r_in_data),
        .i_cfg       (r_cfg),
        .i_head_ref  (w_head_ref),
        .i_press_ref (w_press_ref),
        .o_eval      (w_eval)
    );

    // mode machine, advances once per transfer into the result register
    msw_fsm #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (r_in_data),
        .i_cfg       (r_cfg),
        .i_eval      (w_eval),
        .o_head_ref  (w_head_ref),
        .o_press_ref (w_press_ref),
        .o_result    (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> hdl/msw_eval.sv
// limit evaluator: heading error, pressure delta and per-channel over-limit flags
// combinational only; depends on msw_pkg
`timescale 1ns / 1ps

module msw_eval (
    input  msw_pkg::t_in_item i_item,
    input  msw_pkg::t_cfg     i_cfg,
    input  logic [8:0]        i_head_ref,
    input  logic [14:0]       i_press_ref,
    output msw_pkg::t_eval    o_eval
);
    import msw_pkg::*;

    localparam logic [15:0] DRIFT_CEIL = 16'd10000;
    localparam logic [9:0]  HEAD_CEIL  = 10'd180;
    localparam logic signed [10:0] FULL_TURN = 11'sd360;

    // x * 10 as two shifts and an add
    function automatic logic [11:0] times10(input logic [7:0] v);
        logic [11:0] w;
        w = {4'd0, v};
        return (w << 3) + (w << 1);
    endfunction

    logic signed [10:0] w_cw;
    logic signed [10:0] w_ccw;
    logic [10:0]        w_cw_abs;
    logic [10:0]        w_ccw_abs;
    logic [9:0]         w_herr;
    logic signed [15:0] w_pdelta;
    logic signed [15:0] w_plim;
    logic [11:0]        w_depth_lim;
    logic [11:0]        w_sog_lim;
    logic [11:0]        w_dist_lim;

    always_comb begin
        w_cw      = $signed({2'b00, i_head_ref}) - $signed({2'b00, i_item.heading_now});
        w_ccw     = FULL_TURN - $signed({2'b00, i_head_ref})
                    + $signed({2'b00, i_item.heading_now});
        w_cw_abs  = w_cw[10]  ? 11'(-w_cw)  : 11'(w_cw);
        w_ccw_abs = w_ccw[10] ? 11'(-w_ccw) : 11'(w_ccw);
        w_herr    = (w_cw_abs <= w_ccw_abs) ? w_cw_abs[9:0] : w_ccw_abs[9:0];
    end

    assign w_pdelta    = $signed({1'b0, i_press_ref}) - $signed({1'b0, i_item.pressure_dmb});
    assign w_plim      = $signed({4'd0, times10({3'd0, i_cfg.max_pressure_mb})});
    assign w_depth_lim = times10(i_cfg.min_depth_dm);
    assign w_sog_lim   = times10({2'd0, i_cfg.max_sog_dkn});
    assign w_dist_lim  = times10({1'b0, i_cfg.max_distance_m});

    always_comb begin
        o_eval                 = '0;
        o_eval.all_ok          = (i_cfg.channel_enable & ~i_item.fresh_mask) == '0;
        o_eval.over[CH_POS]    = (i_item.drift_dm > {4'd0, w_dist_lim})
                                 && (i_item.drift_dm < DRIFT_CEIL);
        o_eval.over[CH_DEPTH]  = i_item.depth_cm < {4'd0, w_depth_lim};
        o_eval.over[CH_SOG]    = i_item.sog_cknots > {4'd0, w_sog_lim};
        o_eval.over[CH_WIND]   = i_item.wind_knots > {2'd0, i_cfg.max_wind_kn};
        o_eval.over[CH_HEAD]   = (w_herr > {2'd0, i_cfg.max_heading_deg})
                                 && (w_herr <= HEAD_CEIL);
        o_eval.over[CH_PRESS]  = (w_pdelta > w_plim) || (w_pdelta < -w_plim);
        o_eval.heading_error   = w_herr;
        o_eval.pressure_delta  = w_pdelta;
    end

endmodule

>>> hdl/msw_fsm.sv
// mode machine with persistence counters, references and re-arm time
// updates its state on each item transfer; depends on msw_pkg
`timescale 1ns / 1ps

module msw_fsm #(
    parameter int unsigned COUNT_WIDTH = msw_pkg::COUNT_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  msw_pkg::t_in_item  i_item,
    input  msw_pkg::t_cfg      i_cfg,
    input  msw_pkg::t_eval     i_eval,
    output logic [8:0]         o_head_ref,
    output logic [14:0]        o_press_ref,
    output msw_pkg::t_out_item o_result
);
    import msw_pkg::*;

    typedef enum logic [3:0] {
        ST_WAIT    = 4'b0001,
        ST_STANDBY = 4'b0010,
        ST_WATCH   = 4'b0100,
        ST_ALARM   = 4'b1000
    } t_mode;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    t_mode                  r_mode,  n_mode;
    t_kind                  r_alarm, n_alarm;
    logic                   r_buzzer, n_buzzer;
    logic [COUNT_WIDTH-1:0] r_count [NUM_CNT];
    logic [COUNT_WIDTH-1:0] n_count [NUM_CNT];
    logic [31:0]            r_next_time, n_next_time;
    logic [8:0]             r_head_ref,  n_head_ref;
    logic [14:0]            r_press_ref, n_press_ref;

    logic [NUM_CNT-1:0] w_qual;
    logic               w_checking;
    logic               w_setup;
    logic [9:0]         w_herr;
    logic signed [15:0] w_pdelta;
    t_kind              w_kind;
    logic [31:0]        w_rearm_at;
    t_mode_code         w_mode_code;

    assign w_rearm_at = i_item.time_s
                        + 32'(i_cfg.rearm_minutes) * 32'(SECS_PER_MIN)
                        + 32'(REARM_GUARD_S);

    assign w_checking = (r_mode == ST_WATCH) && (i_item.button != BTN_TOP)
                        && (i_item.time_s > r_next_time);

    // persistence counters, one per channel but pressure
    always_comb begin
        for (int i = 0; i < NUM_CNT; i++) begin
            n_count[i] = r_count[i];
            w_qual[i]  = 1'b0;
            if (w_checking && i_cfg.channel_enable[i]) begin
                if (!i_eval.over[i]) begin
                    n_count[i] = '0;
                end else begin
                    if (r_count[i] != CNT_MAX) begin
                        n_count[i] = r_count[i] + 1'b1;
                    end
                    w_qual[i] = n_count[i] > COUNT_WIDTH'(QUAL_LIMIT[i]);
                end
            end
            if ((r_mode == ST_STANDBY) && (i_item.button == BTN_BOTTOM)
                && (i_cfg.channel_enable != '0)) begin
                n_count[i] = '0;
            end
        end
    end

    // later channels override earlier ones
    always_comb begin
        w_kind = r_alarm;
        if (w_qual[CH_POS])   w_kind = KIND_DIST;
        if (w_qual[CH_DEPTH]) w_kind = KIND_DEPTH;
        if (w_qual[CH_SOG])   w_kind = KIND_SOG;
        if (w_qual[CH_WIND])  w_kind = KIND_WIND;
        if (w_qual[CH_HEAD])  w_kind = KIND_HEAD;
        if (i_cfg.channel_enable[CH_PRESS] && i_eval.over[CH_PRESS]) w_kind = KIND_PRESS;
        if ((w_kind == KIND_NONE) && !i_eval.all_ok) w_kind = KIND_NODATA;
    end

    always_comb begin
        n_mode      = r_mode;
        n_alarm     = r_alarm;
        n_buzzer    = r_buzzer;
        n_next_time = r_next_time;
        n_head_ref  = r_head_ref;
        n_press_ref = r_press_ref;
        w_setup     = 1'b0;
        w_herr      = i_eval.heading_error;
        w_pdelta    = i_eval.pressure_delta;
        unique case (r_mode)
            ST_WAIT: begin
                if (i_item.button == BTN_TOP) begin
                    w_setup  = 1'b1;
                    n_buzzer = 1'b0;
                end else if (i_eval.all_ok) begin
                    n_mode = ST_STANDBY;
                end
            end
            ST_STANDBY: begin
                if (i_item.button == BTN_TOP) begin
                    w_setup  = 1'b1;
                    n_buzzer = 1'b0;
                    n_mode   = ST_WAIT;
                end else if (i_item.button == BTN_BOTTOM) begin
                    if (i_cfg.channel_enable != '0) begin
                        n_next_time = '0;
                        n_mode      = ST_WATCH;
                        n_head_ref  = i_item.heading_now;
                        n_press_ref = i_item.pressure_dmb;
                        w_herr      = '0;
                        w_pdelta    = '0;
                    end
                end else if (i_item.button == BTN_NONE) begin
                    if (!i_eval.all_ok) n_mode = ST_WAIT;
                end
            end
            ST_WATCH: begin
                if (i_item.button == BTN_TOP) begin
                    n_mode = ST_STANDBY;
                end else if (w_checking) begin
                    n_alarm = w_kind;
                    if (w_kind != KIND_NONE) begin
                        n_mode   = ST_ALARM;
                        n_buzzer = 1'b1;
                    end
                end
            end
            ST_ALARM: begin
                if (i_item.button == BTN_TOP) begin
                    if (r_alarm == KIND_PRESS) begin
                        n_press_ref = i_item.pressure_dmb;
                        w_pdelta    = '0;
                    end
                    n_alarm     = KIND_NONE;
                    n_next_time = w_rearm_at;
                    n_mode      = i_eval.all_ok ? ST_WATCH : ST_WAIT;
                    n_buzzer    = 1'b0;
                end else if (r_alarm == KIND_NODATA) begin
                    if (i_eval.all_ok) begin
                        n_alarm  = KIND_NONE;
                        n_buzzer = 1'b0;
                        n_mode   = ST_WATCH;
                    end else begin
                        n_buzzer = ~i_item.time_s[0];
                    end
                end
            end
            default: begin
                n_mode = ST_WAIT;
            end
        endcase
    end

    always_comb begin
        unique case (n_mode)
            ST_STANDBY: w_mode_code = MC_STANDBY;
            ST_WATCH:   w_mode_code = MC_WATCH;
            ST_ALARM:   w_mode_code = MC_ALARM;
            default:    w_mode_code = MC_WAIT;
        endcase
    end

    always_comb begin
        o_result                    = '0;
        o_result.mode               = w_mode_code;
        o_result.alarm_kind         = n_alarm;
        o_result.buzzer_level       = n_buzzer;
        o_result.backlight_flash    = (n_mode == ST_ALARM) && (n_alarm != KIND_NONE)
                                      && i_item.time_s[0];
        o_result.setup_request      = w_setup;
        o_result.rearming           = i_item.time_s <= n_next_time;
        o_result.heading_error      = w_herr;
        o_result.pressure_delta_dmb = w_pdelta;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= ST_WAIT;
            r_alarm     <= KIND_NONE;
            r_buzzer    <= 1'b0;
            r_next_time <= '0;
            r_head_ref  <= '0;
            r_press_ref <= '0;
            for (int i = 0; i < NUM_CNT; i++) begin
                r_count[i] <= '0;
            end
        end else if (i_fire) begin
            r_mode      <= n_mode;
            r_alarm     <= n_alarm;
            r_buzzer    <= n_buzzer;
            r_next_time <= n_next_time;
            r_head_ref  <= n_head_ref;
            r_press_ref <= n_press_ref;
            for (int i = 0; i < NUM_CNT; i++) begin
                r_count[i] <= n_count[i];
            end
        end
    end

    assign o_head_ref  = r_head_ref;
    assign o_press_ref = r_press_ref;

endmodule
